[design/escape_time_fractal_pixel_assert.svh]
// Assertion macros for the escape-time fractal pixel RTL.
// Each macro expects clk and rst_n in scope.
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ETF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ETF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/etf_pkg.sv]
`default_nettype none
package etf_pkg;

  localparam int MAX_IMAGE_SIZE = 1024;
  localparam int FRAC_BITS      = 28;
  localparam int PALETTE_SIZE   = 16;

  localparam int COORD_W = 10;
  localparam int ITER_W  = 10;
  localparam int SIZE_W  = 11;
  localparam int WORD_W  = 32;
  localparam int SCALE_W = 31;
  localparam int COLOR_W = 24;
  localparam int CIDX_W  = 3;

  typedef logic [COORD_W-1:0]       coord_t;
  typedef logic [ITER_W-1:0]        iter_t;
  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [COLOR_W-1:0]       color_t;
  typedef logic [CIDX_W-1:0]        cfg_idx_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t CFG_MODE      = 3'd0;
  localparam cfg_idx_t CFG_DEPTH     = 3'd1;
  localparam cfg_idx_t CFG_IMAGE     = 3'd2;
  localparam cfg_idx_t CFG_ORIGIN_RE = 3'd3;
  localparam cfg_idx_t CFG_ORIGIN_IM = 3'd4;
  localparam cfg_idx_t CFG_SCALE     = 3'd5;
  localparam cfg_idx_t CFG_JULIA_RE  = 3'd6;
  localparam cfg_idx_t CFG_JULIA_IM  = 3'd7;

  localparam logic signed [65:0] WORD_MAX = 66'sd2147483647;
  localparam logic signed [65:0] WORD_MIN = -66'sd2147483648;

  // |z|^2 > 4 with 2*FRAC_BITS fraction bits.
  localparam logic [64:0] ESC_LIMIT = 65'd1 << (2 * FRAC_BITS + 2);

  localparam color_t PALETTE [PALETTE_SIZE] = '{
    24'h09012f, 24'h040449, 24'h000764, 24'h0c2c8a,
    24'h1852b1, 24'h397dd1, 24'h86b5e5, 24'hd3ecf8,
    24'hf1e9bf, 24'hf8c95f, 24'hffaa00, 24'hcc8000,
    24'h995700, 24'h6a3403, 24'h421e0f, 24'h19071a
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP_MUL,
    S_MAP_ADD,
    S_IT_MUL,
    S_IT_UPD,
    S_FIN
  } etf_state_t;

  typedef struct packed {
    logic load_in;
    logic map_mul;
    logic map_add;
    logic it_mul;
    logic it_upd;
    logic load_out;
  } etf_cmd_t;

  typedef struct packed {
    logic stop;
  } etf_sts_t;

  function automatic word_t sat_word(input logic signed [65:0] v);
    if (v > WORD_MAX) begin
      return word_t'(WORD_MAX[31:0]);
    end else if (v < WORD_MIN) begin
      return word_t'(WORD_MIN[31:0]);
    end
    return word_t'(v[31:0]);
  endfunction

endpackage
`default_nettype wire

[design/etf_if.sv]
`default_nettype none
interface etf_in_if import etf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t col;
  coord_t row;
  modport source (output valid, col, row, input ready);
  modport sink (input valid, col, row, output ready);
endinterface

interface etf_out_if import etf_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_col;
  coord_t out_row;
  iter_t  iterations;
  logic   escaped;
  color_t color;
  modport source (output valid, out_col, out_row, iterations, escaped, color, input ready);
  modport sink (input valid, out_col, out_row, iterations, escaped, color, output ready);
endinterface

interface etf_cfg_if import etf_pkg::*; ();
  logic        valid;
  logic        ready;
  cfg_idx_t    index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/etf_dp.sv]
`default_nettype none
module etf_dp import etf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire etf_cmd_t cmd,
  output etf_sts_t      sts,
  input  wire coord_t   in_col,
  input  wire coord_t   in_row,
  input  wire logic     cfg_we,
  input  wire cfg_idx_t cfg_index,
  input  wire logic [31:0] cfg_data,
  output coord_t        out_col,
  output coord_t        out_row,
  output iter_t         out_iter,
  output logic          out_esc,
  output color_t        out_color
);

  logic              mode_r;
  iter_t             depth_r;
  logic [SIZE_W-1:0] size_r;
  word_t             org_re_r;
  word_t             org_im_r;
  logic [SCALE_W-1:0] scale_r;
  word_t             jul_re_r;
  word_t             jul_im_r;

  coord_t            col_r, row_r;
  logic signed [42:0] mul_re_r, mul_im_r;
  word_t             zr_r, zi_r, cr_r, ci_r;
  logic signed [63:0] prr_r, pii_r, pri_r;
  logic [ITER_W:0]   k_r;
  logic              res_esc_r;
  iter_t             res_iter_r;

  coord_t            ocol_r, orow_r;
  iter_t             oiter_r;
  logic              oesc_r;
  color_t            ocolor_r;

  logic [SIZE_W-1:0] size_c;
  coord_t            half;
  logic signed [10:0] dre, dim;
  logic signed [31:0] sscale;
  word_t             p_re, p_im;
  logic signed [65:0] sq;
  word_t             nr, ni;
  logic [64:0]       mag;
  logic              esc_hit;
  logic [ITER_W:0]   km1;
  logic              at_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= 1'b0;
      depth_r  <= 10'd100;
      size_r   <= 11'd512;
      org_re_r <= '0;
      org_im_r <= '0;
      scale_r  <= 31'd2097152;
      jul_re_r <= '0;
      jul_im_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:      mode_r   <= cfg_data[0];
        CFG_DEPTH:     depth_r  <= cfg_data[ITER_W-1:0];
        CFG_IMAGE:     size_r   <= cfg_data[SIZE_W-1:0];
        CFG_ORIGIN_RE: org_re_r <= cfg_data;
        CFG_ORIGIN_IM: org_im_r <= cfg_data;
        CFG_SCALE:     scale_r  <= cfg_data[SCALE_W-1:0];
        CFG_JULIA_RE:  jul_re_r <= cfg_data;
        CFG_JULIA_IM:  jul_im_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    size_c = (size_r > SIZE_W'(MAX_IMAGE_SIZE)) ? SIZE_W'(MAX_IMAGE_SIZE) : size_r;
    half   = size_c[SIZE_W-1:1];
    dre    = $signed({1'b0, col_r}) - $signed({1'b0, half});
    dim    = $signed({1'b0, row_r}) - $signed({1'b0, half});
    sscale = $signed({1'b0, scale_r});
    p_re   = sat_word(66'(org_re_r) + 66'(mul_re_r));
    p_im   = sat_word(66'(org_im_r) - 66'(mul_im_r));

    sq      = 66'(prr_r) - 66'(pii_r);
    nr      = sat_word((sq >>> FRAC_BITS) + 66'(cr_r));
    ni      = sat_word((66'(pri_r) >>> (FRAC_BITS - 1)) + 66'(ci_r));
    // Both squares are non-negative, so the sum is taken unsigned.
    mag     = {1'b0, prr_r} + {1'b0, pii_r};
    esc_hit = (k_r != '0) && (mag > ESC_LIMIT);
    at_end  = (k_r == ({1'b0, depth_r} + 11'd1));
    km1     = k_r - 11'd1;
    sts.stop = esc_hit || at_end;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      col_r <= in_col;
      row_r <= in_row;
    end
    if (cmd.map_mul) begin
      mul_re_r <= 43'(dre) * 43'(sscale);
      mul_im_r <= 43'(dim) * 43'(sscale);
    end
    if (cmd.map_add) begin
      k_r <= '0;
      if (mode_r) begin
        zr_r <= p_re;
        zi_r <= p_im;
        cr_r <= jul_re_r;
        ci_r <= jul_im_r;
      end else begin
        zr_r <= '0;
        zi_r <= '0;
        cr_r <= p_re;
        ci_r <= p_im;
      end
    end
    if (cmd.it_mul) begin
      prr_r <= 64'(zr_r) * 64'(zr_r);
      pii_r <= 64'(zi_r) * 64'(zi_r);
      pri_r <= 64'(zr_r) * 64'(zi_r);
    end
    if (cmd.it_upd) begin
      if (sts.stop) begin
        res_esc_r  <= esc_hit;
        res_iter_r <= esc_hit ? km1[ITER_W-1:0] : depth_r;
      end else begin
        zr_r <= nr;
        zi_r <= ni;
        k_r  <= k_r + 11'd1;
      end
    end
    if (cmd.load_out) begin
      ocol_r   <= col_r;
      orow_r   <= row_r;
      oiter_r  <= res_iter_r;
      oesc_r   <= res_esc_r;
      ocolor_r <= res_esc_r ? PALETTE[res_iter_r[3:0]] : '0;
    end
  end

  assign out_col   = ocol_r;
  assign out_row   = orow_r;
  assign out_iter  = oiter_r;
  assign out_esc   = oesc_r;
  assign out_color = ocolor_r;

endmodule
`default_nettype wire

[design/etf_ctrl.sv]
`default_nettype none
`include "escape_time_fractal_pixel_assert.svh"
module etf_ctrl import etf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output etf_cmd_t      cmd,
  input  wire etf_sts_t sts
);

  etf_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_MAP_MUL;
      S_MAP_MUL: state_nxt = S_MAP_ADD;
      S_MAP_ADD: state_nxt = S_IT_MUL;
      S_IT_MUL:  state_nxt = S_IT_UPD;
      S_IT_UPD:  state_nxt = sts.stop ? S_FIN : S_IT_MUL;
      S_FIN:     if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      S_MAP_MUL: cmd.map_mul = 1'b1;
      S_MAP_ADD: cmd.map_add = 1'b1;
      S_IT_MUL:  cmd.it_mul  = 1'b1;
      S_IT_UPD:  cmd.it_upd  = 1'b1;
      S_FIN:     cmd.load_out = out_free;
      default: ;
    endcase
  end

  // A new result beat wins over the consumer taking the old one.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `ETF_ASSERT_NEXT(a_load_shows_beat, cmd.load_out, out_valid_r,
                   "loaded result is not presented")
  `ETF_ASSERT_NOW(a_no_overwrite, cmd.load_out, !out_valid_r || out_ready,
                  "result register overwritten while its beat waits")
  `ETF_ASSERT_NEXT(a_fin_waits, state_r == S_FIN && out_valid_r && !out_ready,
                   state_r == S_FIN && out_valid_r, "finished pixel left while output stalled")

endmodule
`default_nettype wire

[design/escape_time_fractal_pixel.sv]
// Channel  Role      Payload                                     Accepted when
// in_bus   sink      col, row                                    valid && ready
// out_bus  source    out_col, out_row, iterations, escaped, color  valid && ready
// cfg_bus  sink      index, data (always ready)                  valid && ready
//
// One pixel at a time. An accepted pixel passes the mapping states S_MAP_MUL
// and S_MAP_ADD, then each pass of the z*z + c loop runs S_IT_MUL (three 32x32
// products), then S_IT_UPD (update and magnitude test); S_FIN then loads the
// result register once the output is free.
// Synchronous active-low reset restores the register defaults. The next pixel
// is accepted while the previous result waits; a stalled output holds the
// block in its final cycle.
`default_nettype none
module escape_time_fractal_pixel import etf_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  etf_in_if.sink   in_bus,
  etf_out_if.source out_bus,
  etf_cfg_if.sink  cfg_bus
);

  etf_cmd_t cmd;
  etf_sts_t sts;

  assign cfg_bus.ready = 1'b1;

  etf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  etf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_col    (in_bus.col),
    .in_row    (in_bus.row),
    .cfg_we    (cfg_bus.valid),
    .cfg_index (cfg_bus.index),
    .cfg_data  (cfg_bus.data),
    .out_col   (out_bus.out_col),
    .out_row   (out_bus.out_row),
    .out_iter  (out_bus.iterations),
    .out_esc   (out_bus.escaped),
    .out_color (out_bus.color)
  );

endmodule
`default_nettype wire

[tb/testbench.sv]
module testbench;
  import etf_pkg::*;

  localparam longint Q_ONE = longint'(1) << FRAC_BITS;
  localparam logic [63:0] ESCAPE_MAG = 64'd4 << (2 * FRAC_BITS);
  localparam color_t SHADES [16] = '{
    24'h09012f, 24'h040449, 24'h000764, 24'h0c2c8a,
    24'h1852b1, 24'h397dd1, 24'h86b5e5, 24'hd3ecf8,
    24'hf1e9bf, 24'hf8c95f, 24'hffaa00, 24'hcc8000,
    24'h995700, 24'h6a3403, 24'h421e0f, 24'h19071a
  };

  typedef struct packed {
    coord_t col;
    coord_t row;
    iter_t  iters;
    logic   escaped;
    color_t color;
  } pixel_result_t;

  bit   clk;
  logic rst_n;

  etf_in_if  pix_in ();
  etf_out_if pix_out ();
  etf_cfg_if cfg_if ();

  escape_time_fractal_pixel dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (pix_in),
    .out_bus (pix_out),
    .cfg_bus (cfg_if)
  );

  // Local copy of the register file, kept in step with every accepted write.
  bit          view_julia;
  logic [9:0]  view_depth;
  logic [10:0] view_size;
  longint      view_org_re;
  longint      view_org_im;
  longint      view_scale;
  longint      view_jul_re;
  longint      view_jul_im;

  pixel_result_t pixel_q[$];
  int            fail_count;
  bit            pace_idle = 1'b1;

  always #5 clk = ~clk;

  initial begin
    #30000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint clamp_q(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic pixel_result_t predict_pixel(input coord_t c, input coord_t r);
    pixel_result_t res;
    longint half, p_re, p_im, zr, zi, cr, ci, nr, ni;
    logic [63:0] ar, ai;
    int k;
    half = longint'((view_size > MAX_IMAGE_SIZE ? MAX_IMAGE_SIZE : view_size) / 2);
    p_re = clamp_q(view_org_re + (longint'(c) - half) * view_scale);
    p_im = clamp_q(view_org_im - (longint'(r) - half) * view_scale);
    if (view_julia) begin
      zr = p_re;
      zi = p_im;
      cr = view_jul_re;
      ci = view_jul_im;
    end else begin
      zr = 0;
      zi = 0;
      cr = p_re;
      ci = p_im;
    end
    res.col = c;
    res.row = r;
    res.iters = view_depth;
    res.escaped = 1'b0;
    res.color = '0;
    for (k = 0; k <= int'(view_depth); k++) begin
      nr = clamp_q(((zr * zr - zi * zi) >>> FRAC_BITS) + cr);
      ni = clamp_q(((zr * zi) >>> (FRAC_BITS - 1)) + ci);
      zr = nr;
      zi = ni;
      ar = (zr < 0) ? -zr : zr;
      ai = (zi < 0) ? -zi : zi;
      // The sum of squares carries twice the fraction bits and fits unsigned.
      if (ar * ar + ai * ai > ESCAPE_MAG) begin
        res.iters = iter_t'(k);
        res.escaped = 1'b1;
        res.color = SHADES[k % 16];
        break;
      end
    end
    return res;
  endfunction

  function automatic logic [31:0] q_between(input longint lo, input longint hi);
    return 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
  endfunction

  // All tasks below are entered and left just after a falling edge.
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      CFG_MODE:      view_julia = value[0];
      CFG_DEPTH:     view_depth = value[9:0];
      CFG_IMAGE:     view_size = value[10:0];
      CFG_ORIGIN_RE: view_org_re = longint'(signed'(value));
      CFG_ORIGIN_IM: view_org_im = longint'(signed'(value));
      CFG_SCALE:     view_scale = longint'(value[30:0]);
      CFG_JULIA_RE:  view_jul_re = longint'(signed'(value));
      CFG_JULIA_IM:  view_jul_im = longint'(signed'(value));
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_view(input logic [31:0] mode_w, input logic [31:0] depth_w,
                          input logic [31:0] size_w, input logic [31:0] ore,
                          input logic [31:0] oim, input logic [31:0] scale_w,
                          input logic [31:0] jre, input logic [31:0] jim);
    write_reg(CFG_MODE, mode_w);
    write_reg(CFG_DEPTH, depth_w);
    write_reg(CFG_IMAGE, size_w);
    write_reg(CFG_ORIGIN_RE, ore);
    write_reg(CFG_ORIGIN_IM, oim);
    write_reg(CFG_SCALE, scale_w);
    write_reg(CFG_JULIA_RE, jre);
    write_reg(CFG_JULIA_IM, jim);
  endtask

  // Valid stays high after a beat so back-to-back pixels need no second
  // assignment in the same step; wait_idle lowers it.
  task automatic send_pixel(input coord_t c, input coord_t r);
    while (pace_idle && $urandom_range(0, 99) < 17) begin
      pix_in.valid <= 1'b0;
      @(negedge clk);
    end
    pix_in.valid <= 1'b1;
    pix_in.col <= c;
    pix_in.row <= r;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    pixel_q.push_back(predict_pixel(c, r));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    pix_in.valid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  always @(negedge clk) begin
    pix_out.ready <= !pace_idle || ($urandom_range(0, 99) >= 17);
  end

  always @(posedge clk) begin : result_check
    pixel_result_t want;
    if (rst_n && pix_out.valid && pix_out.ready) begin
      if (pixel_q.size() == 0) begin
        $error("result with nothing pending: col %0d row %0d", pix_out.out_col,
               pix_out.out_row);
        fail_count++;
      end else begin
        want = pixel_q.pop_front();
        if (pix_out.out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, pix_out.out_col);
          fail_count++;
        end
        if (pix_out.out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, pix_out.out_row);
          fail_count++;
        end
        if (pix_out.iterations !== want.iters) begin
          $error("iterations: expected %0d, got %0d", want.iters, pix_out.iterations);
          fail_count++;
        end
        if (pix_out.escaped !== want.escaped) begin
          $error("escaped: expected %0b, got %0b", want.escaped, pix_out.escaped);
          fail_count++;
        end
        if (pix_out.color !== want.color) begin
          $error("color: expected %06h, got %06h", want.color, pix_out.color);
          fail_count++;
        end
      end
    end
  end

  task automatic test_reset_view();
    // Default view spans -2..2 on both axes, so corners escape at once.
    send_pixel(10'd256, 10'd256);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
    wait_idle();
  endtask

  task automatic test_image_size();
    set_view(32'd0, 32'd100, 32'hffff_f800, 32'd0, 32'd0, 32'h0020_0000, 32'd0, 32'd0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    wait_idle();
    write_reg(CFG_IMAGE, 32'd2047);
    send_pixel(10'd512, 10'd512);
    wait_idle();
    write_reg(CFG_IMAGE, 32'd1);
    send_pixel(10'd0, 10'd1023);
    wait_idle();
    write_reg(CFG_IMAGE, 32'd1024);
    send_pixel(10'd1023, 10'd0);
    wait_idle();
  endtask

  task automatic test_saturation();
    set_view(32'd0, 32'd100, 32'd1024, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
             32'd0, 32'd0);
    send_pixel(10'd1023, 10'd0);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd512, 10'd512);
    wait_idle();
    // Smallest step: every pixel lands next to zero and never escapes.
    write_reg(CFG_SCALE, 32'h8000_0001);
    write_reg(CFG_ORIGIN_RE, 32'd0);
    write_reg(CFG_ORIGIN_IM, 32'd0);
    send_pixel(10'd1023, 10'd1023);
    wait_idle();
  endtask

  task automatic test_julia_mode();
    set_view(32'hffff_ffff, 32'd100, 32'd512, 32'd0, 32'd0, 32'h0020_0000,
             32'h8000_0000, 32'h7fff_ffff);
    send_pixel(10'd256, 10'd256);
    send_pixel(10'd0, 10'd0);
    wait_idle();
    write_reg(CFG_JULIA_RE, 32'(-(Q_ONE * 8 / 10)));
    write_reg(CFG_JULIA_IM, 32'(Q_ONE * 156 / 1000));
    send_pixel(10'd200, 10'd250);
    send_pixel(10'd256, 10'd256);
    send_pixel(10'd300, 10'd240);
    wait_idle();
    // Only the low bit of the mode word counts.
    write_reg(CFG_MODE, 32'h0000_0002);
    send_pixel(10'd256, 10'd256);
    wait_idle();
  endtask

  task automatic test_depth_limits();
    set_view(32'd0, 32'hffff_fc00, 32'd512, 32'd0, 32'd0, 32'h0020_0000, 32'd0, 32'd0);
    send_pixel(10'd256, 10'd256);
    send_pixel(10'd0, 10'd0);
    wait_idle();
    write_reg(CFG_DEPTH, 32'h0000_03ff);
    send_pixel(10'd256, 10'd256);
    send_pixel(10'd289, 10'd256);
    wait_idle();
  endtask

  task automatic test_random_views();
    int phase, n, eff;
    bit noisy;
    logic [31:0] mode_w, depth_w, size_w, scale_w, ore, oim, jre, jim;
    coord_t c, r;
    for (phase = 0; phase < 12; phase++) begin
      pace_idle = (phase != 4);
      noisy = (phase == 7 || phase == 10);
      mode_w = $urandom();
      if (noisy) begin
        // Raw register words: mostly saturated points and instant escapes.
        depth_w = ($urandom() & 32'hffff_fc00) | $urandom_range(0, 255);
        size_w = $urandom();
        scale_w = $urandom();
        if (scale_w[30:0] == 0) scale_w = 32'd1;
        ore = $urandom();
        oim = $urandom();
        jre = $urandom();
        jim = $urandom();
      end else begin
        depth_w = ($urandom() & 32'hffff_fc00) | $urandom_range(4, 160);
        case ($urandom_range(0, 3))
          0: size_w = $urandom_range(1, 2047);
          1: size_w = 32'd1024;
          default: size_w = $urandom_range(16, 512);
        endcase
        size_w[31:11] = 21'($urandom());
        eff = (size_w[10:0] > 1024) ? 1024 : int'(size_w[10:0]);
        scale_w = $urandom_range(32'h0800_0000, 32'h4000_0000) / eff;
        scale_w[31] = 1'($urandom_range(0, 1));
        if (mode_w[0]) begin
          ore = q_between(-Q_ONE / 2, Q_ONE / 2);
          oim = q_between(-Q_ONE / 2, Q_ONE / 2);
          jre = q_between(-Q_ONE, Q_ONE / 2);
          jim = q_between(-Q_ONE, Q_ONE);
        end else begin
          ore = q_between(-2 * Q_ONE, Q_ONE * 6 / 10);
          oim = q_between(-Q_ONE * 12 / 10, Q_ONE * 12 / 10);
          jre = $urandom();
          jim = $urandom();
        end
      end
      set_view(mode_w, depth_w, size_w, ore, oim, scale_w, jre, jim);
      eff = (view_size > 1024) ? 1024 : int'(view_size);
      for (n = 0; n < 50; n++) begin
        if (noisy || eff == 0 || $urandom_range(0, 9) == 0) begin
          c = coord_t'($urandom_range(0, 1023));
          r = coord_t'($urandom_range(0, 1023));
        end else begin
          c = coord_t'($urandom_range(0, eff - 1));
          r = coord_t'($urandom_range(0, eff - 1));
        end
        send_pixel(c, r);
      end
      wait_idle();
    end
    pace_idle = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    pix_in.valid = 1'b0;
    pix_in.col = '0;
    pix_in.row = '0;
    pix_out.ready = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_MODE;
    cfg_if.data = '0;
    view_julia = 1'b0;
    view_depth = 10'd100;
    view_size = 11'd512;
    view_org_re = 0;
    view_org_im = 0;
    view_scale = 2097152;
    view_jul_re = 0;
    view_jul_im = 0;
    fail_count = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_view();
    test_image_size();
    test_saturation();
    test_julia_mode();
    test_depth_limits();
    test_random_views();

    wait_idle();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/etf_pkg.sv
design/etf_if.sv
design/etf_dp.sv
design/etf_ctrl.sv
design/escape_time_fractal_pixel.sv
tb/testbench.sv
